@@ hdl/fwsk_pkg.sv @@
// ----------------------------------------------------------------------------
// Four wheel steering kinematics package
// Shared types, widths, constants and arithmetic helpers of the block.
// ----------------------------------------------------------------------------
package fwsk_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int ZW           = 35;   // Q30 angle accumulator, room for +-pi
    localparam int N_W          = 56;   // radicand of the square root cells
    localparam int ROOT_W       = 28;
    localparam int REM_W        = 30;
    localparam int SPD_W        = 30;   // signed rounded speed
    localparam int MAG_W        = 29;   // speed magnitude
    localparam int MAXS_W       = 15;
    localparam int DIV_STEPS    = 15;
    localparam int DIVD_W       = 44;
    localparam int CFG_W        = 16;
    localparam int CORDIC_SHIFT = 24;

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

    localparam logic [2:0] LIMIT_IDX = 3'd4;
    localparam logic [1:0] LAST_WHEEL = 2'd3;

    typedef enum logic [2:0] {
        OP_ACK_SYM   = 3'd0,
        OP_ACK_FRONT = 3'd1,
        OP_ACK_REAR  = 3'd2,
        OP_CRAB      = 3'd3,
        OP_SPIN      = 3'd4,
        OP_XLOCK     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PI_NONE  = 2'd0,
        PI_PLUS  = 2'd1,
        PI_MINUS = 2'd2
    } pi_sel_t;

    typedef enum logic [1:0] {
        CFG_WHEELBASE  = 2'd0,
        CFG_TRACK      = 2'd1,
        CFG_MIN_RADIUS = 2'd2,
        CFG_MAX_SPEED  = 2'd3
    } cfg_idx_t;

    // Control that travels with each vector through the CORDIC / root cells.
    typedef struct packed {
        logic       valid;
        logic [2:0] idx;
        logic       neg;
        logic       zero;
        pi_sel_t    pi_sel;
        logic [2:0] op;
    } cell_tag_t;

    // Control and finished fields that travel with each wheel through the divider.
    typedef struct packed {
        logic        valid;
        logic [1:0]  idx;
        logic        neg;
        logic        limited;
        logic [15:0] ang;
        logic [15:0] spd;
    } div_tag_t;

    function automatic logic [31:0] atan_q30(input int step);
        logic [31:0] a;
        case (step)
            0:  a = 32'h3243F6A8;
            1:  a = 32'h1DAC6705;
            2:  a = 32'h0FADBAFC;
            3:  a = 32'h07F56EA6;
            4:  a = 32'h03FEAB76;
            5:  a = 32'h01FFD55B;
            6:  a = 32'h00FFFAAA;
            7:  a = 32'h007FFF55;
            8:  a = 32'h003FFFEA;
            9:  a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            24: a = 32'h0000003F;
            25: a = 32'h0000001F;
            26: a = 32'h0000000F;
            27: a = 32'h00000007;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Shift right with rounding to nearest, ties away from zero (s >= 1).
    function automatic logic signed [32:0] round_len(input logic signed [32:0] v,
                                                     input int s);
        logic [32:0] mag;
        logic [32:0] r;
        mag = v[32] ? 33'(-v) : 33'(v);
        r = (mag + (33'(1) << (s - 1))) >> s;
        return v[32] ? -$signed(r) : $signed(r);
    endfunction

    // Q30 angle to output units: round half away from zero, saturate to +-32767.
    function automatic logic signed [15:0] angle_round(input logic signed [ZW-1:0] v,
                                                       input int s);
        logic [ZW-1:0] mag;
        logic [ZW-1:0] r;
        logic signed [15:0] a;
        mag = v[ZW-1] ? ZW'(-v) : ZW'(v);
        r = (mag + (ZW'(1) << (s - 1))) >> s;
        if (r > ZW'(32767)) begin
            r = ZW'(32767);
        end
        a = $signed(r[15:0]);
        return v[ZW-1] ? -a : a;
    endfunction

endpackage

@@ hdl/fwsk_cell.sv @@
// ----------------------------------------------------------------------------
// Four wheel steering kinematics cell
// One CORDIC vectoring step and one square root digit, registered.
// ----------------------------------------------------------------------------
module fwsk_cell #(
    parameter int STEP = 0,
    parameter int CW   = 49
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fwsk_pkg::cell_tag_t                   tag_in,
    input  logic signed [CW-1:0]                  x_in,
    input  logic signed [CW-1:0]                  y_in,
    input  logic signed [fwsk_pkg::ZW-1:0]        z_in,
    input  logic [fwsk_pkg::N_W-1:0]              n_in,
    input  logic [fwsk_pkg::REM_W-1:0]            rem_in,
    input  logic [fwsk_pkg::ROOT_W-1:0]           root_in,
    output fwsk_pkg::cell_tag_t                   tag_out,
    output logic signed [CW-1:0]                  x_out,
    output logic signed [CW-1:0]                  y_out,
    output logic signed [fwsk_pkg::ZW-1:0]        z_out,
    output logic [fwsk_pkg::N_W-1:0]              n_out,
    output logic [fwsk_pkg::REM_W-1:0]            rem_out,
    output logic [fwsk_pkg::ROOT_W-1:0]           root_out
);

    logic                                  valid_reg;
    fwsk_pkg::cell_tag_t                   tag_reg;
    logic signed [CW-1:0]                  x_reg, x_next;
    logic signed [CW-1:0]                  y_reg, y_next;
    logic signed [fwsk_pkg::ZW-1:0]        z_reg, z_next;
    logic [fwsk_pkg::N_W-1:0]              n_reg;
    logic [fwsk_pkg::REM_W-1:0]            rem_reg, rem_next;
    logic [fwsk_pkg::ROOT_W-1:0]           root_reg, root_next;
    logic signed [CW-1:0]                  dx, dy;
    logic signed [fwsk_pkg::ZW-1:0]        step_angle;
    logic [fwsk_pkg::REM_W-1:0]            rem_sh, trial;

    // Rotate toward the x axis; the arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        step_angle = $signed({3'b000, fwsk_pkg::atan_q30(STEP)});
        if (!y_in[CW-1]) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + step_angle;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - step_angle;
        end
    end

    // One result bit of the restoring square root.
    always_comb
    begin
        rem_sh = {rem_in[fwsk_pkg::REM_W-3:0], n_in[fwsk_pkg::N_W-1 -: 2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[fwsk_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_in[fwsk_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_in;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        n_reg    <= n_in << 2;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        tag_out       = tag_reg;
        tag_out.valid = valid_reg;
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign n_out    = n_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

@@ hdl/fwsk_div_cell.sv @@
// ----------------------------------------------------------------------------
// Four wheel steering kinematics divider cell
// One restoring quotient bit of the speed scaling division, registered.
// ----------------------------------------------------------------------------
module fwsk_div_cell #(
    parameter int BIT = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fwsk_pkg::div_tag_t                   tag_in,
    input  logic [fwsk_pkg::DIVD_W-1:0]          d_in,
    input  logic [fwsk_pkg::MAG_W-1:0]           m_in,
    input  logic [fwsk_pkg::DIV_STEPS-1:0]       q_in,
    output fwsk_pkg::div_tag_t                   tag_out,
    output logic [fwsk_pkg::DIVD_W-1:0]          d_out,
    output logic [fwsk_pkg::MAG_W-1:0]           m_out,
    output logic [fwsk_pkg::DIV_STEPS-1:0]       q_out
);

    logic                                 valid_reg;
    fwsk_pkg::div_tag_t                   tag_reg;
    logic [fwsk_pkg::DIVD_W-1:0]          d_reg, d_next;
    logic [fwsk_pkg::MAG_W-1:0]           m_reg;
    logic [fwsk_pkg::DIV_STEPS-1:0]       q_reg, q_next;
    logic [fwsk_pkg::DIVD_W-1:0]          m_sh;

    always_comb
    begin
        m_sh = fwsk_pkg::DIVD_W'(m_in) << BIT;
        if (d_in >= m_sh) begin
            d_next = d_in - m_sh;
            q_next = q_in | (fwsk_pkg::DIV_STEPS'(1) << BIT);
        end else begin
            d_next = d_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_in;
        d_reg   <= d_next;
        m_reg   <= m_in;
        q_reg   <= q_next;
    end

    always_comb
    begin
        tag_out       = tag_reg;
        tag_out.valid = valid_reg;
    end

    assign d_out = d_reg;
    assign m_out = m_reg;
    assign q_out = q_reg;

endmodule

@@ hdl/four_wheel_steer_kinematics_top.sv @@
// ----------------------------------------------------------------------------
// Four wheel steering kinematics
// Steering angles and drive speeds of four corner wheels from a motion command.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken at a rising clock edge where start is high and
// busy is low. The block turns it into five vectors (four wheels plus the
// Ackermann angle limit) and sends them, one per cycle, into a row of 28 cells.
// Each cell does one CORDIC vectoring step and one square root digit. Busy is
// high after a transaction and drops while the fifth vector is issued, when a
// new command can already be taken.
// After the row, the four wheels are clamped, the largest speed is found and
// each wheel is sent through a row of 15 divider cells that scales the speeds
// when the limit is exceeded.
// The result is shown for one cycle with done high. The receiver cannot
// stall the block.
// Configuration transactions (cfg_valid with cfg_ready, which is always high)
// write one register each and are meant for times when the block is idle.
// Reset clears all control state and loads the register defaults; no
// transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module four_wheel_steer_kinematics_top #(
    parameter int LENGTH_FRACTION_BITS = 10,
    parameter int ANGLE_FRACTION_BITS  = 13
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [15:0] forward_speed,
    input  logic signed [15:0] lateral_speed,
    input  logic signed [15:0] yaw_rate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] angle_front_left,
    output logic signed [15:0] angle_front_right,
    output logic signed [15:0] angle_rear_left,
    output logic signed [15:0] angle_rear_right,
    output logic signed [15:0] speed_front_left,
    output logic signed [15:0] speed_front_right,
    output logic signed [15:0] speed_rear_left,
    output logic signed [15:0] speed_rear_right,
    output logic               speed_limited
);

    // Vector width follows from the largest rounded yaw term.
    localparam int VW  = 33 - LENGTH_FRACTION_BITS;
    localparam int CW  = VW + 26;
    localparam int ASH = 30 - ANGLE_FRACTION_BITS;
    localparam int NC  = fwsk_pkg::CORDIC_STEPS;
    localparam int ND  = fwsk_pkg::DIV_STEPS;

    // Configuration registers.
    logic [15:0] wb_reg, tw_reg, mtr_reg;
    logic [14:0] max_reg;

    // Command and vector issue.
    logic [2:0]         cmd_op_reg;
    logic signed [15:0] cmd_fwd_reg, cmd_lat_reg, cmd_yaw_reg;
    logic               act_reg;
    logic [2:0]         cnt_reg;
    logic               accept;

    logic signed [32:0]  yaw_ext, tw_ext, wb_ext, prod_t, prod_w;
    logic signed [VW-1:0] half_t, half_w, full_w, fwd_v, lat_v, wb_v, tw_v, mtr_v;
    logic signed [VW-1:0] vx, vy;
    logic                 full;

    logic                 p_valid_reg;
    logic [2:0]           p_idx_reg, p_op_reg;
    logic                 p_full_reg;
    logic signed [VW-1:0] p_x_reg, p_y_reg;

    // Fold and square stage feeding the first cell.
    logic                    neg;
    logic signed [VW:0]      x_wide, y_wide, xf, yf;
    logic signed [2*VW-1:0]  sqx, sqy;
    logic [2*VW-1:0]         nsum;
    fwsk_pkg::cell_tag_t     s_tag;
    logic                    s_valid_reg;
    fwsk_pkg::cell_tag_t     s_tag_reg;
    logic signed [CW-1:0]    s_x_reg, s_y_reg;
    logic [fwsk_pkg::N_W-1:0] s_n_reg;

    // Cell row.
    fwsk_pkg::cell_tag_t              tag_c  [0:NC];
    logic signed [CW-1:0]             x_c    [0:NC];
    logic signed [CW-1:0]             y_c    [0:NC];
    logic signed [fwsk_pkg::ZW-1:0]   z_c    [0:NC];
    logic [fwsk_pkg::N_W-1:0]         n_c    [0:NC];
    logic [fwsk_pkg::REM_W-1:0]       rem_c  [0:NC];
    logic [fwsk_pkg::ROOT_W-1:0]      root_c [0:NC];

    // Exit of the row: angle and speed of each vector.
    logic signed [fwsk_pkg::ZW-1:0]    zsel, zadj;
    logic [fwsk_pkg::ROOT_W:0]         root_adj;
    logic signed [fwsk_pkg::SPD_W-1:0] spd_mag, spd_sgn;
    logic                              e1_valid_reg;
    logic [2:0]                        e1_idx_reg, e1_op_reg;
    logic signed [15:0]                e1_ang_reg;
    logic signed [fwsk_pkg::SPD_W-1:0] e1_spd_reg;

    // Collection of one command's wheels and the clamp.
    logic signed [15:0]                col_ang_reg [0:3];
    logic signed [fwsk_pkg::SPD_W-1:0] col_spd_reg [0:3];
    logic                              b_valid_reg;
    logic signed [15:0]                b_ang_reg  [0:3];
    logic signed [15:0]                b_ang_next [0:3];
    logic signed [fwsk_pkg::SPD_W-1:0] b_spd_reg  [0:3];
    logic signed [fwsk_pkg::SPD_W-1:0] b_spd_next [0:3];

    // Largest speed and the division feeder.
    logic [fwsk_pkg::MAG_W-1:0]        b_mag [0:3];
    logic [fwsk_pkg::MAG_W-1:0]        max01, max23, m_all;
    logic                              c_act_reg;
    logic [1:0]                        c_cnt_reg;
    logic signed [15:0]                c_ang_reg [0:3];
    logic [fwsk_pkg::MAG_W-1:0]        c_mag_reg [0:3];
    logic [15:0]                       c_spd_reg [0:3];
    logic                              c_neg_reg [0:3];
    logic [fwsk_pkg::MAG_W-1:0]        c_m_reg;
    logic                              c_lim_reg;

    fwsk_pkg::div_tag_t                f_tag;
    logic                              f_valid_reg;
    fwsk_pkg::div_tag_t                f_tag_reg;
    logic [fwsk_pkg::DIVD_W-1:0]       f_d_reg;
    logic [fwsk_pkg::MAG_W-1:0]        f_m_reg;

    fwsk_pkg::div_tag_t                dtag_c [0:ND];
    logic [fwsk_pkg::DIVD_W-1:0]       d_c    [0:ND];
    logic [fwsk_pkg::MAG_W-1:0]        m_c    [0:ND];
    logic [ND-1:0]                     q_c    [0:ND];

    // Result assembly.
    logic signed [15:0] q_signed, spd_final;
    logic signed [15:0] h_ang_reg [0:2];
    logic signed [15:0] h_spd_reg [0:2];
    logic               done_reg;
    logic               lim_out_reg;
    logic signed [15:0] o_ang_reg [0:3];
    logic signed [15:0] o_spd_reg [0:3];

    // ------------------------------------------------------------------
    // Configuration port: always ready, one register per transaction.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wb_reg  <= 16'd1024;
            tw_reg  <= 16'd1024;
            mtr_reg <= 16'd2048;
            max_reg <= 15'd2048;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fwsk_pkg::CFG_WHEELBASE:  wb_reg  <= cfg_data;
                fwsk_pkg::CFG_TRACK:      tw_reg  <= cfg_data;
                fwsk_pkg::CFG_MIN_RADIUS: mtr_reg <= cfg_data;
                fwsk_pkg::CFG_MAX_SPEED:  max_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command capture. The issue counter walks the four wheels and then the
    // limit vector; the next command can be taken while the limit vector
    // is being issued.
    // ------------------------------------------------------------------
    assign busy   = act_reg && (cnt_reg != fwsk_pkg::LIMIT_IDX);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (accept) begin
            act_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (act_reg) begin
            if (cnt_reg == fwsk_pkg::LIMIT_IDX) begin
                act_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_op_reg  <= op;
            cmd_fwd_reg <= forward_speed;
            cmd_lat_reg <= lateral_speed;
            cmd_yaw_reg <= yaw_rate;
        end
    end

    // Yaw terms: one product each for track and wheelbase, rounded half away
    // from zero. The half wheelbase and full wheelbase share a product.
    always_comb
    begin
        yaw_ext = 33'(cmd_yaw_reg);
        tw_ext  = 33'($signed({1'b0, tw_reg}));
        wb_ext  = 33'($signed({1'b0, wb_reg}));
        prod_t  = yaw_ext * tw_ext;
        prod_w  = yaw_ext * wb_ext;
        half_t  = VW'(fwsk_pkg::round_len(prod_t, LENGTH_FRACTION_BITS + 1));
        half_w  = VW'(fwsk_pkg::round_len(prod_w, LENGTH_FRACTION_BITS + 1));
        full_w  = VW'(fwsk_pkg::round_len(prod_w, LENGTH_FRACTION_BITS));
        fwd_v   = VW'(cmd_fwd_reg);
        lat_v   = VW'(cmd_lat_reg);
        wb_v    = VW'($signed({1'b0, wb_reg}));
        tw_v    = VW'($signed({1'b0, tw_reg}));
        mtr_v   = VW'($signed({1'b0, mtr_reg}));
    end

    // Wheel order is front left, front right, rear left, rear right:
    // counter bit 1 selects the rear axle and bit 0 the right side.
    always_comb
    begin
        vx   = '0;
        vy   = '0;
        full = 1'b0;
        if (cnt_reg == fwsk_pkg::LIMIT_IDX) begin
            // The Ackermann limit angle: atan2(k * wheelbase, 2 * radius - track).
            full = 1'b1;
            vx   = (mtr_v <<< 1) - tw_v;
            vy   = (cmd_op_reg == fwsk_pkg::OP_ACK_SYM) ? wb_v : (wb_v <<< 1);
        end else begin
            case (cmd_op_reg)
                fwsk_pkg::OP_ACK_SYM, fwsk_pkg::OP_ACK_FRONT, fwsk_pkg::OP_ACK_REAR:
                begin
                    vx = cnt_reg[0] ? (fwd_v + half_t) : (fwd_v - half_t);
                    if (cmd_op_reg == fwsk_pkg::OP_ACK_FRONT) begin
                        vy = cnt_reg[1] ? '0 : full_w;
                    end else if (cmd_op_reg == fwsk_pkg::OP_ACK_REAR) begin
                        vy = cnt_reg[1] ? -full_w : '0;
                    end else begin
                        vy = cnt_reg[1] ? -half_w : half_w;
                    end
                end
                fwsk_pkg::OP_CRAB:
                begin
                    vx = fwd_v;
                    vy = lat_v;
                end
                fwsk_pkg::OP_SPIN:
                begin
                    vx = cnt_reg[0] ? half_t : -half_t;
                    vy = cnt_reg[1] ? -half_w : half_w;
                end
                fwsk_pkg::OP_XLOCK:
                begin
                    // Each wheel points along the diagonal through the body center.
                    full = 1'b1;
                    vx   = cnt_reg[1] ? wb_v : -wb_v;
                    vy   = cnt_reg[0] ? tw_v : -tw_v;
                end
                default:
                begin
                    vx = '0;
                    vy = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg  <= cnt_reg;
        p_op_reg   <= cmd_op_reg;
        p_full_reg <= full;
        p_x_reg    <= vx;
        p_y_reg    <= vy;
    end

    // ------------------------------------------------------------------
    // Fold into the right half plane and form the radicand. A wheel vector
    // that points backward turns around and drives in reverse; a full
    // circle angle instead gets pi added or taken off at the exit.
    // ------------------------------------------------------------------
    always_comb
    begin
        x_wide = (VW + 1)'(p_x_reg);
        y_wide = (VW + 1)'(p_y_reg);
        neg    = p_x_reg[VW-1];
        xf     = neg ? -x_wide : x_wide;
        yf     = neg ? -y_wide : y_wide;
        sqx    = (2 * VW)'(p_x_reg) * (2 * VW)'(p_x_reg);
        sqy    = (2 * VW)'(p_y_reg) * (2 * VW)'(p_y_reg);
        nsum   = $unsigned(sqx) + $unsigned(sqy);
        s_tag.valid = p_valid_reg;
        s_tag.idx   = p_idx_reg;
        s_tag.op    = p_op_reg;
        s_tag.neg   = neg && !p_full_reg;
        s_tag.zero  = (p_y_reg == '0);
        if (p_full_reg && neg) begin
            s_tag.pi_sel = p_y_reg[VW-1] ? fwsk_pkg::PI_MINUS : fwsk_pkg::PI_PLUS;
        end else begin
            s_tag.pi_sel = fwsk_pkg::PI_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_valid_reg <= 1'b0;
        end else begin
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_tag_reg <= s_tag;
        s_x_reg   <= CW'(xf) <<< fwsk_pkg::CORDIC_SHIFT;
        s_y_reg   <= CW'(yf) <<< fwsk_pkg::CORDIC_SHIFT;
        s_n_reg   <= fwsk_pkg::N_W'(nsum);
    end

    always_comb
    begin
        tag_c[0]       = s_tag_reg;
        tag_c[0].valid = s_valid_reg;
    end

    assign x_c[0]    = s_x_reg;
    assign y_c[0]    = s_y_reg;
    assign z_c[0]    = '0;
    assign n_c[0]    = s_n_reg;
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    // ------------------------------------------------------------------
    // Row of cells: CORDIC step and square root digit side by side, so the
    // angle and the magnitude of a vector leave the row together.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NC; g++) begin : g_cell
        fwsk_cell #(
            .STEP (g),
            .CW   (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag_in   (tag_c[g]),
            .x_in     (x_c[g]),
            .y_in     (y_c[g]),
            .z_in     (z_c[g]),
            .n_in     (n_c[g]),
            .rem_in   (rem_c[g]),
            .root_in  (root_c[g]),
            .tag_out  (tag_c[g+1]),
            .x_out    (x_c[g+1]),
            .y_out    (y_c[g+1]),
            .z_out    (z_c[g+1]),
            .n_out    (n_c[g+1]),
            .rem_out  (rem_c[g+1]),
            .root_out (root_c[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Row exit: a vector on the x axis has angle zero before the half plane
    // correction. The root rounds up when the remainder exceeds it.
    // ------------------------------------------------------------------
    always_comb
    begin
        zsel = tag_c[NC].zero ? '0 : z_c[NC];
        case (tag_c[NC].pi_sel)
            fwsk_pkg::PI_PLUS:  zadj = zsel + fwsk_pkg::PI_Q30;
            fwsk_pkg::PI_MINUS: zadj = zsel - fwsk_pkg::PI_Q30;
            default:            zadj = zsel;
        endcase
        root_adj = {1'b0, root_c[NC]} +
                   ((rem_c[NC] > fwsk_pkg::REM_W'(root_c[NC])) ?
                    (fwsk_pkg::ROOT_W + 1)'(1) : '0);
        spd_mag  = $signed(fwsk_pkg::SPD_W'(root_adj));
        spd_sgn  = tag_c[NC].neg ? -spd_mag : spd_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            e1_valid_reg <= 1'b0;
        end else begin
            e1_valid_reg <= tag_c[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_idx_reg <= tag_c[NC].idx;
        e1_op_reg  <= tag_c[NC].op;
        e1_ang_reg <= fwsk_pkg::angle_round(zadj, ASH);
        e1_spd_reg <= spd_sgn;
    end

    // ------------------------------------------------------------------
    // Collect the four wheels; the limit vector closes the command and, in the
    // Ackermann modes, the clamp is applied against it. X lock drives no wheel,
    // unknown modes give all zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            b_ang_next[i] = col_ang_reg[i];
            b_spd_next[i] = col_spd_reg[i];
            case (e1_op_reg)
                fwsk_pkg::OP_ACK_SYM, fwsk_pkg::OP_ACK_FRONT, fwsk_pkg::OP_ACK_REAR:
                begin
                    if (col_ang_reg[i] > e1_ang_reg) begin
                        b_ang_next[i] = e1_ang_reg;
                    end else if (col_ang_reg[i] < -e1_ang_reg) begin
                        b_ang_next[i] = -e1_ang_reg;
                    end
                end
                fwsk_pkg::OP_CRAB, fwsk_pkg::OP_SPIN: ;
                fwsk_pkg::OP_XLOCK:
                begin
                    b_spd_next[i] = '0;
                end
                default:
                begin
                    b_ang_next[i] = '0;
                    b_spd_next[i] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= e1_valid_reg && (e1_idx_reg == fwsk_pkg::LIMIT_IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1_valid_reg && (e1_idx_reg != fwsk_pkg::LIMIT_IDX)) begin
            col_ang_reg[e1_idx_reg[1:0]] <= e1_ang_reg;
            col_spd_reg[e1_idx_reg[1:0]] <= e1_spd_reg;
        end
        if (e1_valid_reg && (e1_idx_reg == fwsk_pkg::LIMIT_IDX)) begin
            for (int i = 0; i < 4; i++) begin
                b_ang_reg[i] <= b_ang_next[i];
                b_spd_reg[i] <= b_spd_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Largest magnitude over the four wheels, then one wheel per cycle into
    // the divider row.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            b_mag[i] = b_spd_reg[i][fwsk_pkg::SPD_W-1] ?
                       fwsk_pkg::MAG_W'(-b_spd_reg[i]) : fwsk_pkg::MAG_W'(b_spd_reg[i]);
        end
        max01 = (b_mag[0] > b_mag[1]) ? b_mag[0] : b_mag[1];
        max23 = (b_mag[2] > b_mag[3]) ? b_mag[2] : b_mag[3];
        m_all = (max01 > max23) ? max01 : max23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_act_reg <= 1'b0;
            c_cnt_reg <= '0;
        end else if (b_valid_reg) begin
            c_act_reg <= 1'b1;
            c_cnt_reg <= '0;
        end else if (c_act_reg) begin
            if (c_cnt_reg == fwsk_pkg::LAST_WHEEL) begin
                c_act_reg <= 1'b0;
            end
            c_cnt_reg <= c_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg) begin
            for (int i = 0; i < 4; i++) begin
                c_ang_reg[i] <= b_ang_reg[i];
                c_mag_reg[i] <= b_mag[i];
                c_spd_reg[i] <= b_spd_reg[i][15:0];
                c_neg_reg[i] <= b_spd_reg[i][fwsk_pkg::SPD_W-1];
            end
            c_m_reg   <= m_all;
            c_lim_reg <= (m_all > fwsk_pkg::MAG_W'(max_reg));
        end
    end

    always_comb
    begin
        f_tag.valid   = c_act_reg;
        f_tag.idx     = c_cnt_reg;
        f_tag.neg     = c_neg_reg[c_cnt_reg];
        f_tag.limited = c_lim_reg;
        f_tag.ang     = c_ang_reg[c_cnt_reg];
        f_tag.spd     = c_spd_reg[c_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= c_act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_tag_reg <= f_tag;
        f_d_reg   <= fwsk_pkg::DIVD_W'(c_mag_reg[c_cnt_reg]) * fwsk_pkg::DIVD_W'(max_reg);
        f_m_reg   <= c_m_reg;
    end

    always_comb
    begin
        dtag_c[0]       = f_tag_reg;
        dtag_c[0].valid = f_valid_reg;
    end

    assign d_c[0] = f_d_reg;
    assign m_c[0] = f_m_reg;
    assign q_c[0] = '0;

    // Divider row: quotient bits from the top down, magnitude * limit / max.
    for (genvar g = 0; g < ND; g++) begin : g_div
        fwsk_div_cell #(
            .BIT (ND - 1 - g)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .tag_in  (dtag_c[g]),
            .d_in    (d_c[g]),
            .m_in    (m_c[g]),
            .q_in    (q_c[g]),
            .tag_out (dtag_c[g+1]),
            .d_out   (d_c[g+1]),
            .m_out   (m_c[g+1]),
            .q_out   (q_c[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Result assembly: the last wheel loads the output registers and raises
    // done for a single cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        q_signed  = $signed(16'(q_c[ND]));
        if (dtag_c[ND].limited) begin
            spd_final = dtag_c[ND].neg ? -q_signed : q_signed;
        end else begin
            spd_final = $signed(dtag_c[ND].spd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= dtag_c[ND].valid && (dtag_c[ND].idx == fwsk_pkg::LAST_WHEEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dtag_c[ND].valid && (dtag_c[ND].idx != fwsk_pkg::LAST_WHEEL)) begin
            h_ang_reg[dtag_c[ND].idx] <= $signed(dtag_c[ND].ang);
            h_spd_reg[dtag_c[ND].idx] <= spd_final;
        end
        if (dtag_c[ND].valid && (dtag_c[ND].idx == fwsk_pkg::LAST_WHEEL)) begin
            for (int i = 0; i < 3; i++) begin
                o_ang_reg[i] <= h_ang_reg[i];
                o_spd_reg[i] <= h_spd_reg[i];
            end
            o_ang_reg[3] <= $signed(dtag_c[ND].ang);
            o_spd_reg[3] <= spd_final;
            lim_out_reg  <= dtag_c[ND].limited;
        end
    end

    assign done              = done_reg;
    assign angle_front_left  = o_ang_reg[0];
    assign angle_front_right = o_ang_reg[1];
    assign angle_rear_left   = o_ang_reg[2];
    assign angle_rear_right  = o_ang_reg[3];
    assign speed_front_left  = o_spd_reg[0];
    assign speed_front_right = o_spd_reg[1];
    assign speed_rear_left   = o_spd_reg[2];
    assign speed_rear_right  = o_spd_reg[3];
    assign speed_limited     = lim_out_reg;

endmodule

@@ tb/four_wheel_steer_kinematics_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four wheel steering kinematics testbench
// Drives motion commands and register writes into the block, predicts the
// wheel angles and speeds of every accepted command and checks each result.
// ----------------------------------------------------------------------------
module four_wheel_steer_kinematics_top_test;

    // Codes the block must answer with an all-zero result.
    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Cycles with no transaction of any kind before the run is declared hung.
    // It lies far above the command latency and the longest sender gap, so
    // this is many times the slowest legal stretch.
    localparam int HANG_LIMIT = 3000;
    // Pipeline depth plus margin; used before register writes and at the end.
    localparam int SETTLE_CYCLES = 64;

    // One set of wheel outputs, in the order front left, front right,
    // rear left, rear right.
    typedef struct {
        logic signed [15:0] angle[4];
        logic signed [15:0] speed[4];
        logic               limited;
    } wheel_set_t;

    // Scoreboard: holds its own copy of the registers, computes the wheel
    // outputs of each accepted command and compares results in order.
    class steer_scoreboard;
        longint     wheelbase_r;
        longint     track_r;
        longint     min_radius_r;
        longint     max_speed_r;
        wheel_set_t pending_sets[$];
        int         mismatches;

        function new();
            wheelbase_r  = 1024;
            track_r      = 1024;
            min_radius_r = 2048;
            max_speed_r  = 2048;
            mismatches   = 0;
        endfunction

        function void set_register(fwsk_pkg::cfg_idx_t idx, logic [15:0] value);
            case (idx)
                fwsk_pkg::CFG_WHEELBASE:  wheelbase_r  = value;
                fwsk_pkg::CFG_TRACK:      track_r      = value;
                fwsk_pkg::CFG_MIN_RADIUS: min_radius_r = value;
                fwsk_pkg::CFG_MAX_SPEED:  max_speed_r  = value[14:0];
                default: ;
            endcase
        endfunction

        // Rounds to nearest with ties away from zero after a right shift.
        function longint shift_round(longint v, int s);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
            return (v < 0) ? -mag : mag;
        endfunction

        // Vectoring CORDIC for a vector in the right half plane, Q30 result.
        function longint vector_angle_q30(longint x, longint y);
            longint arctan[28];
            longint xx;
            longint yy;
            longint z;
            longint dx;
            longint dy;
            arctan = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                       64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                       64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                       64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                       64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                       64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                       64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007};
            if (y == 0) begin
                return 0;
            end
            xx = x * 64'sd16777216;
            yy = y * 64'sd16777216;
            z  = 0;
            for (int i = 0; i < 28; i++) begin
                // Arithmetic shifts of signed values round toward minus infinity.
                dx = yy >>> i;
                dy = xx >>> i;
                if (yy >= 0) begin
                    xx += dx;
                    yy -= dy;
                    z  += arctan[i];
                end else begin
                    xx -= dx;
                    yy += dy;
                    z  -= arctan[i];
                end
            end
            return z;
        endfunction

        function longint to_angle_units(longint z30);
            longint r;
            r = shift_round(z30, 17);
            if (r > 32767) r = 32767;
            if (r < -32767) r = -32767;
            return r;
        endfunction

        function longint full_circle_angle(longint y, longint x);
            longint h;
            if (x >= 0) begin
                return to_angle_units(vector_angle_q30(x, y));
            end
            h = vector_angle_q30(-x, -y);
            return to_angle_units((y >= 0) ? h + 64'sd3373259426 : h - 64'sd3373259426);
        endfunction

        // Integer square root of x*x + y*y, rounded to nearest.
        function longint vector_length(longint x, longint y);
            logic [63:0] n;
            logic [63:0] r;
            logic [63:0] b;
            n = x * x + y * y;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (n > r) r++;
            return longint'(r);
        endfunction

        function void note_command(logic [2:0] mode, logic signed [15:0] fwd,
                                   logic signed [15:0] lat, logic signed [15:0] yaw);
            wheel_set_t w;
            longint xs[4];
            longint ys[4];
            longint ang[4];
            longint spd[4];
            longint half_t;
            longint half_w;
            longint full_w;
            longint vx;
            longint vy;
            longint s;
            longint peak;
            longint lim;
            longint mag;
            xs = '{1, 1, -1, -1};
            ys = '{1, -1, 1, -1};
            half_t = shift_round(longint'(yaw) * track_r, 11);
            half_w = shift_round(longint'(yaw) * wheelbase_r, 11);
            full_w = shift_round(longint'(yaw) * wheelbase_r, 10);
            w.limited = 1'b0;
            for (int i = 0; i < 4; i++) begin
                ang[i] = 0;
                spd[i] = 0;
            end
            if (mode == fwsk_pkg::OP_XLOCK) begin
                for (int i = 0; i < 4; i++)
                    ang[i] = full_circle_angle(-ys[i] * track_r, -xs[i] * wheelbase_r);
            end else if (mode < fwsk_pkg::OP_XLOCK) begin
                for (int i = 0; i < 4; i++) begin
                    vx = longint'(fwd) - ys[i] * half_t;
                    vy = xs[i] * half_w;
                    case (mode)
                        fwsk_pkg::OP_ACK_FRONT: vy = (xs[i] > 0) ? full_w : 0;
                        fwsk_pkg::OP_ACK_REAR:  vy = (xs[i] > 0) ? 0 : -full_w;
                        fwsk_pkg::OP_CRAB: begin
                            vx = fwd;
                            vy = lat;
                        end
                        fwsk_pkg::OP_SPIN:      vx = -ys[i] * half_t;
                        default: ;
                    endcase
                    s = vector_length(vx, vy);
                    // Fold the vector into the right half plane, reversing the wheel.
                    if (vx < 0) begin
                        vx = -vx;
                        vy = -vy;
                        s  = -s;
                    end
                    ang[i] = to_angle_units(vector_angle_q30(vx, vy));
                    spd[i] = s;
                end
                if (mode <= fwsk_pkg::OP_ACK_REAR) begin
                    lim = full_circle_angle(((mode == fwsk_pkg::OP_ACK_SYM) ? 1 : 2) *
                                            wheelbase_r, 2 * min_radius_r - track_r);
                    for (int i = 0; i < 4; i++) begin
                        if (ang[i] > lim) ang[i] = lim;
                        if (ang[i] < -lim) ang[i] = -lim;
                    end
                end
                peak = 0;
                for (int i = 0; i < 4; i++) begin
                    mag = (spd[i] < 0) ? -spd[i] : spd[i];
                    if (mag > peak) peak = mag;
                end
                if (peak > max_speed_r) begin
                    w.limited = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        mag = (spd[i] < 0) ? -spd[i] : spd[i];
                        mag = mag * max_speed_r / peak;
                        spd[i] = (spd[i] < 0) ? -mag : mag;
                    end
                end
            end
            for (int i = 0; i < 4; i++) begin
                w.angle[i] = ang[i][15:0];
                w.speed[i] = spd[i][15:0];
            end
            pending_sets.push_back(w);
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_result(wheel_set_t got);
            wheel_set_t want;
            string names[4];
            names = '{"front_left", "front_right", "rear_left", "rear_right"};
            if (pending_sets.size() == 0) begin
                report("result without command", 1, 0);
                return;
            end
            want = pending_sets.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got.angle[i] !== want.angle[i])
                    report({"angle_", names[i]}, got.angle[i], want.angle[i]);
                if (got.speed[i] !== want.speed[i])
                    report({"speed_", names[i]}, got.speed[i], want.speed[i]);
            end
            if (got.limited !== want.limited)
                report("speed_limited", got.limited, want.limited);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic signed [15:0] forward_speed;
    logic signed [15:0] lateral_speed;
    logic signed [15:0] yaw_rate;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               done;
    logic signed [15:0] angle_front_left;
    logic signed [15:0] angle_front_right;
    logic signed [15:0] angle_rear_left;
    logic signed [15:0] angle_rear_right;
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_rear_left;
    logic signed [15:0] speed_rear_right;
    logic               speed_limited;

    steer_scoreboard sb;
    int              quiet_cycles;
    int              item_count;
    bit              no_gaps;

    four_wheel_steer_kinematics_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .op                (op),
        .forward_speed     (forward_speed),
        .lateral_speed     (lateral_speed),
        .yaw_rate          (yaw_rate),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .angle_front_left  (angle_front_left),
        .angle_front_right (angle_front_right),
        .angle_rear_left   (angle_rear_left),
        .angle_rear_right  (angle_rear_right),
        .speed_front_left  (speed_front_left),
        .speed_front_right (speed_front_right),
        .speed_rear_left   (speed_rear_left),
        .speed_rear_right  (speed_rear_right),
        .speed_limited     (speed_limited)
    );

    // An 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor. Everything is sampled at the rising edge; the stimulus only
    // changes at the falling edge, so the sampled values are settled.
    // A command transaction is noted when start is high and busy is low, and
    // each done strobe is compared with the oldest prediction. The same block
    // runs the hang watchdog, which resets on any transaction.
    always @(posedge clk)
    begin
        wheel_set_t got;
        bit         moved;
        moved = 1'b0;
        if (rst_n) begin
            if (start && !busy) begin
                sb.note_command(op, forward_speed, lateral_speed, yaw_rate);
                moved = 1'b1;
            end
            if (done) begin
                got.angle = '{angle_front_left, angle_front_right,
                              angle_rear_left, angle_rear_right};
                got.speed = '{speed_front_left, speed_front_right,
                              speed_rear_left, speed_rear_right};
                got.limited = speed_limited;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("four_wheel_steer_kinematics_top verification failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge with the command
    // taken. Unless a gap follows, start stays high for back to back commands.
    task send_command(logic [2:0] mode, logic signed [15:0] fwd,
                      logic signed [15:0] lat, logic signed [15:0] yaw);
        start         <= 1'b1;
        op            <= mode;
        forward_speed <= fwd;
        lateral_speed <= lat;
        yaw_rate      <= yaw;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        item_count++;
        // About one command in six is followed by a gap, except in the
        // stretch where the sender keeps start high continuously.
        if (!no_gaps && $urandom_range(99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // Waits until every predicted result has been checked, then lets the
    // pipeline empty out. Returns at a falling edge with start low.
    task drain_results();
        start <= 1'b0;
        while (sb.pending_sets.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Leaves cfg_valid high so that writes can follow one another; the
    // caller drops it after the last write.
    task write_register(fwsk_pkg::cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    task load_geometry(logic [15:0] wb, logic [15:0] tw, logic [15:0] rmin,
                       logic [15:0] vmax);
        write_register(fwsk_pkg::CFG_WHEELBASE, wb);
        write_register(fwsk_pkg::CFG_TRACK, tw);
        write_register(fwsk_pkg::CFG_MIN_RADIUS, rmin);
        write_register(fwsk_pkg::CFG_MAX_SPEED, vmax);
        cfg_valid <= 1'b0;
    endtask

    // Random command. Valid modes dominate; the unused codes show up rarely.
    // Half of the speeds are kept moderate so that unlimited results are
    // common, the rest span the whole field.
    task send_random_command();
        logic [2:0]         mode;
        logic signed [15:0] f;
        logic signed [15:0] l;
        logic signed [15:0] y;
        if ($urandom_range(99) < 5) begin
            mode = OP_UNUSED_LO + 3'($urandom_range(1));
        end else begin
            mode = 3'($urandom_range(fwsk_pkg::OP_XLOCK));
        end
        if ($urandom_range(1)) begin
            f = 16'($urandom);
            l = 16'($urandom);
            y = 16'($urandom);
        end else begin
            f = 16'($signed($urandom_range(6000)) - 3000);
            l = 16'($signed($urandom_range(6000)) - 3000);
            y = 16'($signed($urandom_range(4000)) - 2000);
        end
        send_command(mode, f, l, y);
    endtask

    task run_random(int count);
        repeat (count) send_random_command();
    endtask

    initial
    begin
        sb            = new();
        quiet_cycles  = 0;
        item_count    = 0;
        no_gaps       = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = fwsk_pkg::OP_ACK_SYM;
        forward_speed = '0;
        lateral_speed = '0;
        yaw_rate      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = fwsk_pkg::CFG_WHEELBASE;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed commands under the reset geometry: every mode, the field
        // extremes, a zero wheel vector and the unused mode codes.
        send_command(fwsk_pkg::OP_ACK_SYM, 16'sd1000, 16'sd0, 16'sd500);
        send_command(fwsk_pkg::OP_ACK_SYM, -16'sd32768, 16'sd0, 16'sd32767);
        send_command(fwsk_pkg::OP_ACK_SYM, 16'sd32767, 16'sd0, -16'sd32768);
        send_command(fwsk_pkg::OP_ACK_FRONT, 16'sd800, 16'sd0, -16'sd700);
        send_command(fwsk_pkg::OP_ACK_FRONT, 16'sd0, 16'sd0, 16'sd32767);
        send_command(fwsk_pkg::OP_ACK_REAR, -16'sd900, 16'sd0, 16'sd400);
        send_command(fwsk_pkg::OP_ACK_REAR, 16'sd32767, 16'sd0, -16'sd32768);
        send_command(fwsk_pkg::OP_CRAB, 16'sd0, 16'sd0, 16'sd0);
        send_command(fwsk_pkg::OP_CRAB, 16'sd32767, 16'sd32767, 16'sd0);
        send_command(fwsk_pkg::OP_CRAB, -16'sd32768, -16'sd32768, 16'sd0);
        send_command(fwsk_pkg::OP_CRAB, -16'sd500, 16'sd300, 16'sd0);
        send_command(fwsk_pkg::OP_CRAB, 16'sd0, -16'sd1200, 16'sd0);
        send_command(fwsk_pkg::OP_SPIN, 16'sd0, 16'sd0, 16'sd1000);
        send_command(fwsk_pkg::OP_SPIN, 16'sd0, 16'sd0, -16'sd32768);
        send_command(fwsk_pkg::OP_SPIN, 16'sd0, 16'sd0, 16'sd0);
        send_command(fwsk_pkg::OP_XLOCK, 16'sd1234, -16'sd55, 16'sd777);
        send_command(OP_UNUSED_LO, 16'sd1000, 16'sd1000, 16'sd1000);
        send_command(OP_UNUSED_HI, -16'sd1, -16'sd1, -16'sd1);

        run_random(80);

        // Hold off entirely until every outstanding result has come back.
        drain_results();
        run_random(20);

        // Every register at zero.
        drain_results();
        load_geometry(16'd0, 16'd0, 16'd0, 16'd0);
        send_command(fwsk_pkg::OP_XLOCK, 16'sd0, 16'sd0, 16'sd0);
        run_random(50);

        // Every register at its top value; one long stretch with no gaps.
        drain_results();
        load_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        no_gaps = 1'b1;
        run_random(90);
        no_gaps = 1'b0;

        // Wide track with a small radius: the limit lies beyond a right angle
        // and never clamps.
        drain_results();
        load_geometry(16'd1500, 16'd60000, 16'd100, 16'd20000);
        run_random(70);

        // Small speed limit, so nearly every command is scaled.
        drain_results();
        load_geometry(16'd3000, 16'd900, 16'd1, 16'd1);
        run_random(60);

        // Random geometry.
        drain_results();
        load_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(70);

        drain_results();
        if (sb.mismatches == 0 && sb.pending_sets.size() == 0) begin
            $display("four_wheel_steer_kinematics_top verification clean");
        end else begin
            $display("four_wheel_steer_kinematics_top verification failed");
        end
        $finish;
    end

endmodule
